// File: rtl/fst_pkg.sv
// Shared types and constants for the flow statistics table.
// No dependencies; imported by fst_match, fst_update and the top level.
package fst_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [15:0] LEN_ALL_ONES = 16'hFFFF;
  localparam logic [31:0] GAP_ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [2:0]  DUE_PERIOD   = 3'd5;

  localparam int IN_DATA_W  = 336;
  localparam int OUT_DATA_W = 264;

  typedef struct packed {
    logic [63:0] src_high;
    logic [63:0] src_low;
    logic [63:0] dst_high;
    logic [63:0] dst_low;
    logic [31:0] ports;
  } key_t;

  typedef struct packed {
    logic [31:0] first_seen;
    logic [31:0] last_seen;
    logic [31:0] count_all;
    logic [2:0]  count_mod5;
    logic [31:0] count_fwd;
    logic [31:0] sum_fwd;
    logic [31:0] sum_bwd;
    logic [15:0] len_min;
    logic [15:0] len_max;
    logic [31:0] gap_total;
    logic [31:0] gap_low;
    logic [31:0] gap_high;
  } stat_t;

  typedef struct packed {
    logic key_eq;
    logic age_lt;
  } match_t;

endpackage

// File: rtl/fst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/fst_match.sv
// Shared compare unit of the scan: key equality and start-time order.
// Depends on fst_pkg.
module fst_match import fst_pkg::*; (
  input  key_t        key_a,
  input  key_t        key_b,
  input  logic [31:0] ts_a,
  input  logic [31:0] ts_b,
  output match_t      res
);

  assign res.key_eq = (key_a == key_b);
  assign res.age_lt = (ts_a < ts_b);

endmodule

// File: rtl/fst_update.sv
// Statistics update of one entry for one packet.
// Depends on fst_pkg.
module fst_update import fst_pkg::*; (
  input  stat_t       cur,
  input  logic [15:0] len,
  input  logic        fwd,
  input  logic [31:0] now,
  output stat_t       nxt,
  output logic        due
);

  logic [31:0] gap;
  logic [31:0] cnt;
  logic [2:0]  mod5;

  always_comb begin
    gap  = now - cur.last_seen;
    cnt  = cur.count_all + 32'd1;
    // residue follows the count, including its wrap to zero
    if (cnt == 32'd0) begin
      mod5 = 3'd0;
    end else if (cur.count_mod5 == DUE_PERIOD - 3'd1) begin
      mod5 = 3'd0;
    end else begin
      mod5 = cur.count_mod5 + 3'd1;
    end
    nxt            = cur;
    nxt.count_all  = cnt;
    nxt.count_mod5 = mod5;
    nxt.last_seen  = now;
    if (fwd) begin
      nxt.count_fwd = cur.count_fwd + 32'd1;
      nxt.sum_fwd   = cur.sum_fwd + {16'd0, len};
    end else begin
      nxt.sum_bwd   = cur.sum_bwd + {16'd0, len};
    end
    if (len < cur.len_min) nxt.len_min = len;
    if (len > cur.len_max) nxt.len_max = len;
    if (cnt > 32'd1) begin
      nxt.gap_total = cur.gap_total + gap;
      if (gap < cur.gap_low)  nxt.gap_low  = gap;
      if (gap > cur.gap_high) nxt.gap_high = gap;
    end
    due = (cnt != 32'd0) && (mod5 == 3'd0);
  end

endmodule

// File: rtl/flow_statistics_table_top.sv
// Top level of the flow statistics table: sequencer, key/stat RAMs, output register.
// Depends on fst_pkg, fst_ram, fst_match and fst_update.
//
// A packet request is accepted in an idle cycle. On a miss the scan covers
// all N used entries (at most 16) before the result is loaded into the
// output register. A hit on entry k ends the scan early. The used entries
// are read one per cycle from the key and statistics RAMs and checked by a
// single compare unit, then the update state writes the updated entry and
// loads the result register. s_tready is high only while the sequencer is
// idle, so a new request is not taken until the last one has been written
// back; a finished result may wait in the output register while the next
// request is taken, and that request stalls in its update state until the
// waiting result is read. No clearing pass follows reset.
module flow_statistics_table_top import fst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // src_addr_high, src_addr_low, dst_addr_high, dst_addr_low,
  // source port, destination port, packet_length, timestamp
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // forward_dir
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // entry_slot, entry_created, packets_total, packets_forward, bytes_forward,
  // bytes_backward, length_min, length_max, gap_sum, gap_min, gap_max,
  // analyze_due, 2 bits zero pad
  output logic [OUT_DATA_W-1:0] m_tdata
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  state_t           state;
  key_t             req_key;
  logic [15:0]      req_len;
  logic             req_fwd;
  logic [31:0]      req_now;
  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] rd_cnt;
  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_idx;
  logic [IDX_W-1:0] oldest_idx;
  logic [31:0]      oldest_ts;
  logic [IDX_W-1:0] slot;
  logic             created;
  stat_t            cur;

  key_t             key_rd;
  logic [$bits(stat_t)-1:0] stat_rd_bits;
  stat_t            stat_rd;
  match_t           cmp;
  stat_t            upd;
  logic             upd_due;
  logic             issue;
  logic             hit;
  logic             take_oldest;
  logic [IDX_W-1:0] oldest_sel;
  logic             upd_go;
  stat_t            fresh;
  logic [IDX_W+3:0] slot_ext;

  assign stat_rd = stat_t'(stat_rd_bits);

  fst_ram #(.WIDTH($bits(key_t)), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk     (clk),
    .wr_en   (upd_go),
    .wr_addr (slot),
    .wr_data (req_key),
    .rd_addr (rd_cnt[IDX_W-1:0]),
    .rd_data (key_rd)
  );

  fst_ram #(.WIDTH($bits(stat_t)), .DEPTH(TABLE_ENTRIES)) u_stat_ram (
    .clk     (clk),
    .wr_en   (upd_go),
    .wr_addr (slot),
    .wr_data (upd),
    .rd_addr (rd_cnt[IDX_W-1:0]),
    .rd_data (stat_rd_bits)
  );

  fst_match u_match (
    .key_a (key_rd),
    .key_b (req_key),
    .ts_a  (stat_rd.first_seen),
    .ts_b  (oldest_ts),
    .res   (cmp)
  );

  fst_update u_update (
    .cur (cur),
    .len (req_len),
    .fwd (req_fwd),
    .now (req_now),
    .nxt (upd),
    .due (upd_due)
  );

  always_comb begin
    issue       = (state == ST_SCAN) && (rd_cnt < used);
    hit         = cmp_valid && cmp.key_eq;
    take_oldest = cmp_valid && ((cmp_idx == '0) || cmp.age_lt);
    oldest_sel  = take_oldest ? cmp_idx : oldest_idx;
    upd_go      = (state == ST_UPD) && (!m_tvalid || m_tready);
    s_tready    = (state == ST_IDLE);
    fresh            = '0;
    fresh.first_seen = req_now;
    fresh.last_seen  = req_now;
    fresh.len_min    = LEN_ALL_ONES;
    fresh.gap_low    = GAP_ALL_ONES;
    slot_ext         = {4'd0, slot};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      used      <= '0;
      cmp_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state     <= ST_SCAN;
            cmp_valid <= 1'b0;
          end
        end
        ST_SCAN: begin
          cmp_valid <= issue;
          if (hit) begin
            state <= ST_UPD;
          end else if (!issue) begin
            state <= ST_UPD;
            if (used < CNT_W'(TABLE_ENTRIES)) used <= used + 1'b1;
          end
        end
        ST_UPD: begin
          if (upd_go) begin
            state    <= ST_IDLE;
            m_tvalid <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      rd_cnt  <= '0;
      req_key <= '{s_tdata[63:0], s_tdata[127:64], s_tdata[191:128], s_tdata[255:192],
                   {s_tdata[271:256], s_tdata[287:272]}};
      req_len <= s_tdata[303:288];
      req_now <= s_tdata[335:304];
      req_fwd <= s_tuser;
    end
    if (state == ST_SCAN) begin
      if (issue) rd_cnt <= rd_cnt + 1'b1;
      cmp_idx <= rd_cnt[IDX_W-1:0];
      if (take_oldest) begin
        oldest_idx <= cmp_idx;
        oldest_ts  <= stat_rd.first_seen;
      end
      if (hit) begin
        slot    <= cmp_idx;
        created <= 1'b0;
        cur     <= stat_rd;
      end else if (!issue) begin
        // miss: next free entry, or the oldest once full
        slot    <= (used < CNT_W'(TABLE_ENTRIES)) ? used[IDX_W-1:0] : oldest_sel;
        created <= 1'b1;
        cur     <= fresh;
      end
    end
    if (upd_go) begin
      m_tdata <= {2'b00, upd_due, upd.gap_high, upd.gap_low, upd.gap_total,
                  upd.len_max, upd.len_min, upd.sum_bwd, upd.sum_fwd,
                  upd.count_fwd, upd.count_all, created, slot_ext[3:0]};
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count beyond table size");

  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD && !created) |-> ({1'b0, slot} < (IDX_W+1)'(used)))
    else $error("matched slot outside used entries");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    upd_go |=> (m_tvalid && state == ST_IDLE))
    else $error("update did not load a result");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (rd_cnt <= used))
    else $error("scan read past used entries");

endmodule

// File: test/tb_top.sv
// Testbench for flow_statistics_table_top: directed, random and back-pressure packet requests
// checked against a behavioral flow table. Depends on fst_pkg and the RTL.
module tb_top import fst_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CYCLES = 2000000;

  typedef struct {
    logic [63:0] sh, sl, dh, dl;
    logic [15:0] sp, dp, len;
    logic        fwd;
    logic [31:0] ts;
  } pkt_t;

  typedef struct packed {
    logic [3:0]  slot;
    logic        created;
    logic [31:0] total, fwd_cnt, fwd_sum, bwd_sum;
    logic [15:0] lmin, lmax;
    logic [31:0] gsum, gmin, gmax;
    logic        due;
  } flow_res_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic s_tuser = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_DATA_W-1:0] m_tdata;

  flow_statistics_table_top DUT (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // model flow table
  int          n_used;
  key_t        tbl_key [TABLE_ENTRIES];
  logic [31:0] tbl_first [TABLE_ENTRIES], tbl_last [TABLE_ENTRIES];
  logic [31:0] tbl_cnt [TABLE_ENTRIES], tbl_fcnt [TABLE_ENTRIES];
  logic [31:0] tbl_fb [TABLE_ENTRIES], tbl_bb [TABLE_ENTRIES];
  logic [15:0] tbl_lmin [TABLE_ENTRIES], tbl_lmax [TABLE_ENTRIES];
  logic [31:0] tbl_gs [TABLE_ENTRIES], tbl_gl [TABLE_ENTRIES], tbl_gh [TABLE_ENTRIES];

  flow_res_t expected_stats[$];
  int errors = 0;
  int cycles = 0;
  int hold_off = 0;
  int hold_req = 0;
  int hold_seen = 0;
  bit rx_random = 1;

  // recent flow keys for reuse
  pkt_t flows[$];

  function automatic flow_res_t predict_flow(pkt_t p);
    key_t k;
    int slot, oldest;
    bit found;
    flow_res_t r;
    logic [31:0] gap;
    k = '{p.sh, p.sl, p.dh, p.dl, {p.sp, p.dp}};
    found = 0; slot = 0; oldest = 0;
    for (int i = 0; i < n_used; i++) begin
      if (tbl_key[i] == k) begin
        slot = i; found = 1; break;
      end
      if (tbl_first[i] < tbl_first[oldest]) oldest = i;
    end
    if (!found) begin
      if (n_used < TABLE_ENTRIES) begin
        slot = n_used; n_used++;
      end else slot = oldest;
      tbl_key[slot] = k;
      tbl_first[slot] = p.ts; tbl_last[slot] = p.ts;
      tbl_cnt[slot] = 0; tbl_fcnt[slot] = 0; tbl_fb[slot] = 0; tbl_bb[slot] = 0;
      tbl_lmin[slot] = LEN_ALL_ONES; tbl_lmax[slot] = 0;
      tbl_gs[slot] = 0; tbl_gl[slot] = GAP_ALL_ONES; tbl_gh[slot] = 0;
    end
    gap = p.ts - tbl_last[slot];
    tbl_cnt[slot] = tbl_cnt[slot] + 1;
    if (p.fwd) begin
      tbl_fcnt[slot] = tbl_fcnt[slot] + 1;
      tbl_fb[slot] = tbl_fb[slot] + p.len;
    end else tbl_bb[slot] = tbl_bb[slot] + p.len;
    if (p.len < tbl_lmin[slot]) tbl_lmin[slot] = p.len;
    if (p.len > tbl_lmax[slot]) tbl_lmax[slot] = p.len;
    if (tbl_cnt[slot] > 1) begin
      tbl_gs[slot] = tbl_gs[slot] + gap;
      if (gap < tbl_gl[slot]) tbl_gl[slot] = gap;
      if (gap > tbl_gh[slot]) tbl_gh[slot] = gap;
    end
    tbl_last[slot] = p.ts;
    r.slot = slot[3:0]; r.created = !found;
    r.total = tbl_cnt[slot]; r.fwd_cnt = tbl_fcnt[slot];
    r.fwd_sum = tbl_fb[slot]; r.bwd_sum = tbl_bb[slot];
    r.lmin = tbl_lmin[slot]; r.lmax = tbl_lmax[slot];
    r.gsum = tbl_gs[slot]; r.gmin = tbl_gl[slot]; r.gmax = tbl_gh[slot];
    r.due = (tbl_cnt[slot] != 0) && (tbl_cnt[slot] % 5 == 0);
    return r;
  endfunction

  task automatic send_packet(pkt_t p);
    @(posedge clk);
    s_tvalid <= 1;
    s_tdata <= {p.ts, p.len, p.dp, p.sp, p.dl, p.dh, p.sl, p.sh};
    s_tuser <= p.fwd;
    do @(posedge clk); while (!s_tready);
    expected_stats.push_back(predict_flow(p));
    if ($urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  endtask

  task automatic drain;
    s_tvalid <= 0;
    while (expected_stats.size() != 0) @(posedge clk);
  endtask

  function automatic pkt_t rand_pkt();
    pkt_t p;
    p.sh = {$urandom, $urandom}; p.sl = {$urandom, $urandom};
    p.dh = {$urandom, $urandom}; p.dl = {$urandom, $urandom};
    p.sp = 16'($urandom); p.dp = 16'($urandom); p.len = 16'($urandom);
    p.fwd = 1'($urandom); p.ts = $urandom;
    return p;
  endfunction

  task automatic test_directed;
    pkt_t p, q;
    p = '{64'h0, 64'h0, 64'h0, 64'h0, 16'h0, 16'h0, 16'h0, 1'b0, 32'h0};
    send_packet(p);
    p.len = 16'hFFFF; p.fwd = 1; p.ts = 32'hFFFF_FFFF;
    send_packet(p);
    // gap wraps modulo 2^32
    p.len = 16'd100; p.ts = 32'd5;
    send_packet(p);
    p.fwd = 0; p.ts = 32'd6; send_packet(p);
    p.ts = 32'd6; send_packet(p); // fifth packet, zero gap
    q = '{'1, '1, '1, '1, 16'hFFFF, 16'hFFFF, 16'h0, 1'b1, 32'h8000_0000};
    send_packet(q);
    // differs only in one port
    q.dp = 16'hFFFE; send_packet(q);
    q.sp = 16'hFFFE; q.dp = 16'hFFFF; send_packet(q);
    // fill table, then replacement with first_seen ties
    for (int i = 0; i < 12; i++) begin
      q = rand_pkt(); q.ts = (i < 6) ? 32'd0 : 32'd7;
      send_packet(q);
    end
    q = rand_pkt(); send_packet(q);
    q = rand_pkt(); send_packet(q);
    drain();
  endtask

  task automatic test_random(int n);
    pkt_t p;
    int burst;
    logic [31:0] clock_now;
    clock_now = $urandom;
    while (n > 0) begin
      burst = $urandom_range(1, 30);
      for (int j = 0; j < burst && n > 0; j++, n--) begin
        if (flows.size() != 0 && $urandom_range(0, 9) < 7) begin
          p = flows[$urandom_range(0, flows.size() - 1)];
          p.len = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom);
          p.fwd = 1'($urandom);
        end else begin
          p = rand_pkt();
          flows.push_back(p);
          if (flows.size() > 24) void'(flows.pop_front());
        end
        clock_now = ($urandom_range(0, 19) == 0) ? $urandom :
                    clock_now + $urandom_range(0, 1000);
        p.ts = clock_now;
        send_packet(p);
      end
      s_tvalid <= 0;
      repeat ($urandom_range(0, 25)) @(posedge clk);
    end
  endtask

  task automatic test_backpressure;
    pkt_t p;
    hold_req++;
    for (int i = 0; i < 8; i++) begin
      p = flows.size() ? flows[i % flows.size()] : rand_pkt();
      p.ts = p.ts + 3; send_packet(p);
    end
    drain();
  endtask

  // receiver: random stalls, long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_off  <= 400;
      m_tready  <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 0;
    end else if (rx_random)
      m_tready <= ($urandom_range(0, 3) != 0) || (cycles % 1000 > 800);
    else m_tready <= 1;
  end

  // result checker
  always @(posedge clk) begin
    flow_res_t e, a;
    if (!rst && m_tvalid && m_tready) begin
      {a.due, a.gmax, a.gmin, a.gsum, a.lmax, a.lmin, a.bwd_sum, a.fwd_sum,
       a.fwd_cnt, a.total, a.created, a.slot} = m_tdata[261:0];
      if (expected_stats.size() == 0) begin
        $display("%t unexpected result %h", $realtime, m_tdata);
        errors++;
      end else begin
        e = expected_stats.pop_front();
        if (a != e) begin
          errors++;
          $display("%t mismatch exp slot=%0d new=%0d tot=%0d fc=%0d fb=%0d bb=%0d",
                   $realtime, e.slot, e.created, e.total, e.fwd_cnt, e.fwd_sum, e.bwd_sum);
          $display("    exp lmin=%0d lmax=%0d gs=%0d gmin=%0d gmax=%0d due=%0d",
                   e.lmin, e.lmax, e.gsum, e.gmin, e.gmax, e.due);
          $display("    act slot=%0d new=%0d tot=%0d fc=%0d fb=%0d bb=%0d",
                   a.slot, a.created, a.total, a.fwd_cnt, a.fwd_sum, a.bwd_sum);
          $display("    act lmin=%0d lmax=%0d gs=%0d gmin=%0d gmax=%0d due=%0d",
                   a.lmin, a.lmax, a.gsum, a.gmin, a.gmax, a.due);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    n_used = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    test_directed();
    test_random(360);
    test_backpressure();
    test_random(360);
    drain();
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_stats.size() == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end
endmodule
